// ----- sv/conv2d_valid_u8_saturating_core_macros.svh -----
// Assertion macros for the 2-D valid-mode convolution core.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef CONV2D_VALID_U8_SATURATING_CORE_MACROS_SVH
`define CONV2D_VALID_U8_SATURATING_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define C2D_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define C2D_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define C2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define C2D_ASSERT_HOLDS(lbl, expr, msg)
`define C2D_ASSERT_IMPL(lbl, ante, cons, msg)
`define C2D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/c2d_pkg.sv -----
// Shared constants and types for the 2-D valid-mode convolution core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c2d_pkg;

  localparam int IMG_WIDTH  = 128;
  localparam int IMG_HEIGHT = 128;
  localparam int KERNEL     = 3;

  localparam int COL_W = $clog2(IMG_WIDTH);
  localparam int ROW_W = $clog2(IMG_HEIGHT);
  localparam int LANES = (KERNEL > 1) ? KERNEL - 1 : 1;

  localparam int PIX_W  = 8;
  localparam int WGT_W  = 8;
  localparam int PROD_W = PIX_W + WGT_W + 1;
  localparam int ACC_W  = 21;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_WROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS  = 3'd5;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [WGT_W-1:0]  wgt_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef pix_t [KERNEL-1:0][KERNEL-1:0] win_t;
  typedef wgt_t [KERNEL-1:0][KERNEL-1:0] kern_t;
  typedef pix_t [LANES-1:0]              line_t;

  typedef struct packed {
    logic valid;
    logic frame_end;
  } c2d_tag_t;

endpackage

`default_nettype wire

// ----- sv/conv2d_valid_u8_saturating_core.sv -----
// Streaming 3x3 valid-mode correlation of an 8-bit raster image, result clamped to 0..255.
// Throughput: one pixel per cycle unless out_stall holds the pipeline; the line memory
// is read once and written once per pixel. Registered steps: memory read, window,
// products, row sums, bias add and clamp. Uses c2d_pkg and c2d_mac.
// Reset (synchronous, rst_n low) clears counters, window, pipeline valids and
// configuration registers; line memory is not reset; its stale words reach no result.
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_valid_u8_saturating_core_macros.svh"

module conv2d_valid_u8_saturating_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [c2d_pkg::PIX_W-1:0]        in_pixel_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [c2d_pkg::PIX_W-1:0]             out_pixel_out,
  output logic                                  out_frame_end,
  input  wire logic                             cfg_we,
  input  wire logic [c2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [c2d_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import c2d_pkg::*;

  kern_t kern_r;
  acc_t  bias_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept, last_col, emit_nxt, fend_nxt, pos_ok;

  logic             v1_r, emit1_r, fend1_r;
  pix_t             pix1_r;
  logic [COL_W-1:0] col1_r;
  line_t            rd_r, wr_line;
  line_t            line_mem [IMG_WIDTH];

  win_t             win_r, win_nxt;
  logic             v2_r, fend2_r;

  logic             rdy1, go1, rdy2, go2, mac_ready;
  c2d_tag_t         tag;

  // request flow
  assign go2      = v2_r && mac_ready;
  assign rdy2     = !v2_r || go2;
  assign go1      = v1_r && rdy2;
  assign rdy1     = !v1_r || go1;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r <= '0;
      bias_r <= '0;
    end else if (cfg_we) begin
      for (int k = 0; k < KERNEL; k++) begin
        if (cfg_index == REG_WROW0 + CFG_IDX_W'(k)) begin
          for (int kc = 0; kc < KERNEL; kc++) begin
            kern_r[k][kc] <= cfg_wdata[kc*WGT_W +: WGT_W];
          end
        end
      end
      if (cfg_index == REG_BIAS) begin
        bias_r <= cfg_wdata[ACC_W-1:0];
      end
    end
  end

  // raster position
  assign last_col = (col_r == COL_W'(IMG_WIDTH - 1));
  assign emit_nxt = (row_r >= ROW_W'(KERNEL - 1)) && (col_r >= COL_W'(KERNEL - 1));
  assign fend_nxt = (row_r == ROW_W'(IMG_HEIGHT - 1)) && last_col;
  assign pos_ok   = (col_r <= COL_W'(IMG_WIDTH - 1)) && (row_r <= ROW_W'(IMG_HEIGHT - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_W'(IMG_HEIGHT - 1)) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      v1_r  <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (rdy1) begin
        v1_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1_r  <= in_pixel_in;
      col1_r  <= col_r;
      emit1_r <= emit_nxt;
      fend1_r <= fend_nxt;
    end
  end

  // line memory: one word per column holds the older lines, oldest in lane 0.
  // A column is revisited only a full line later, so read and write never collide.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[col_r];
    end
    if (go1) begin
      line_mem[col1_r] <= wr_line;
    end
  end

  always_comb begin
    for (int j = 0; j < LANES - 1; j++) begin
      wr_line[j] = rd_r[j+1];
    end
    wr_line[LANES-1] = pix1_r;
  end

  always_comb begin
    win_nxt = win_r;
    for (int kr = 0; kr < KERNEL; kr++) begin
      for (int kc = 0; kc < KERNEL - 1; kc++) begin
        win_nxt[kr][kc] = win_r[kr][kc+1];
      end
    end
    for (int kr = 0; kr < KERNEL - 1; kr++) begin
      win_nxt[kr][KERNEL-1] = rd_r[kr];
    end
    win_nxt[KERNEL-1][KERNEL-1] = pix1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      v2_r  <= 1'b0;
    end else begin
      if (go1) begin
        win_r <= win_nxt;
      end
      if (rdy2) begin
        v2_r <= go1 && emit1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      fend2_r <= fend1_r;
    end
  end

  assign tag.valid     = v2_r;
  assign tag.frame_end = fend2_r;

  c2d_mac u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .tag_i         (tag),
    .win_i         (win_r),
    .kern_i        (kern_r),
    .bias_i        (bias_r),
    .ready_o       (mac_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

  `C2D_ASSERT_HOLDS(a_pos_range, pos_ok, "raster position out of range")
  `C2D_ASSERT_IMPL(a_fend_emits, v1_r && fend1_r, emit1_r, "frame end on a pixel with no result")
  `C2D_ASSERT_NEXT(a_col_capture, accept, v1_r && (col1_r == $past(col_r)), "stage one lost column")
  `C2D_ASSERT_IMPL(a_no_stall_empty, !v1_r, !in_stall, "input stalled with stage one empty")

endmodule

`default_nettype wire

// ----- sv/c2d_mac.sv -----
// Multiply-accumulate pipeline: window products, row sums, bias add and clamp.
// Depends on c2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2d_mac (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire c2d_pkg::c2d_tag_t  tag_i,
  input  wire c2d_pkg::win_t      win_i,
  input  wire c2d_pkg::kern_t     kern_i,
  input  wire c2d_pkg::acc_t      bias_i,
  output logic                    ready_o,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output c2d_pkg::pix_t           out_pixel_out,
  output logic                    out_frame_end
);
  import c2d_pkg::*;

  prod_t [KERNEL-1:0][KERNEL-1:0] prod_r, prod_nxt;
  acc_t  [KERNEL-1:0]             rsum_r, rsum_nxt;
  logic  vp_r, fp_r, vs_r, fs_r;
  logic  o_valid_r, o_fend_r;
  pix_t  o_pix_r, o_pix_nxt;
  logic  rdy_o, go_s, rdy_s, go_p, rdy_p;

  assign rdy_o   = !o_valid_r || !out_stall;
  assign go_s    = vs_r && rdy_o;
  assign rdy_s   = !vs_r || go_s;
  assign go_p    = vp_r && rdy_s;
  assign rdy_p   = !vp_r || go_p;
  assign ready_o = rdy_p;

  always_comb begin
    for (int kr = 0; kr < KERNEL; kr++) begin
      for (int kc = 0; kc < KERNEL; kc++) begin
        prod_nxt[kr][kc] = PROD_W'(kern_i[kr][kc]) * PROD_W'($signed({1'b0, win_i[kr][kc]}));
      end
    end
  end

  always_comb begin
    for (int kr = 0; kr < KERNEL; kr++) begin
      rsum_nxt[kr] = '0;
      for (int kc = 0; kc < KERNEL; kc++) begin
        rsum_nxt[kr] = rsum_nxt[kr] + ACC_W'(prod_r[kr][kc]);
      end
    end
  end

  // sum wraps at ACC_W bits before the clamp
  always_comb begin
    acc_t acc;
    acc = bias_i;
    for (int kr = 0; kr < KERNEL; kr++) begin
      acc = acc + rsum_r[kr];
    end
    if (acc[ACC_W-1]) begin
      o_pix_nxt = '0;
    end else if (|acc[ACC_W-2:PIX_W]) begin
      o_pix_nxt = PIX_MAX;
    end else begin
      o_pix_nxt = acc[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r      <= 1'b0;
      vs_r      <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (rdy_p) begin
        vp_r <= tag_i.valid;
      end
      if (rdy_s) begin
        vs_r <= go_p;
      end
      if (rdy_o) begin
        o_valid_r <= go_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_i.valid && rdy_p) begin
      prod_r <= prod_nxt;
      fp_r   <= tag_i.frame_end;
    end
    if (go_p) begin
      rsum_r <= rsum_nxt;
      fs_r   <= fp_r;
    end
    if (go_s) begin
      o_pix_r  <= o_pix_nxt;
      o_fend_r <= fs_r;
    end
  end

  assign out_valid     = o_valid_r;
  assign out_pixel_out = o_pix_r;
  assign out_frame_end = o_fend_r;

endmodule

`default_nettype wire
